FILE: rtl/bilinear_upscale_integer_top_defines.svh
// Assertion macros shared by the checker of the bilinear upscaler.
`ifndef BILINEAR_UPSCALE_INTEGER_TOP_DEFINES_SVH
`define BILINEAR_UPSCALE_INTEGER_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define BUI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bilinear upscaler: next-cycle check failed");

// Consequent must hold in the same cycle, checked during reset as well.
`define BUI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error("bilinear upscaler: same-cycle check failed");

`endif

FILE: rtl/bui_pkg.sv
// Shared types and constants of the bilinear upscaler.
package bui_pkg;

    // Widths of the item fields and configuration registers.
    localparam int PIX_W   = 8;
    localparam int OROW_W  = 15;
    localparam int OCOL_W  = 13;
    localparam int ROW_W   = 12;
    localparam int CFGW_W  = 11;
    localparam int CFGH_W  = 13;
    localparam int CFGF_W  = 4;
    localparam int CFGD_W  = 13;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = 14;
    localparam int RCP_W   = 25;
    localparam int RCP_SH  = 24;
    localparam int HEIGHT_MAX = 4096;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FACTOR = 2'd2;

    // Rounded-up reciprocals of f*f scaled by 2^24, indexed by f-1; exact floor
    // division for every weighted sum below 2^14.
    localparam logic [RCP_W-1:0] RECIP [8] = '{
        25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
        25'd671089,   25'd466034,  25'd342393,  25'd262144
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic capture;
        logic calc;
        logic load;
        logic shift;
    } bui_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic produce;
        logic out_free;
        logic blk_last;
    } bui_status_t;

endpackage

FILE: rtl/bilinear_upscale_integer_top.sv
// Top level of the integer bilinear upscaler.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_pixel, s_frame_start
//  m_       out        m_valid/m_ready    m_out_pixel, m_out_row, m_out_col, m_block_last
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wr_data
//
// An item in source row 0 or column 0 passes through accept, then the line buffer read.
// Any other item passes through accept and the read, then a sum state and a divide-and-emit state
// per result, set by the single shared weighting and reciprocal unit.
// A stalled output register holds the sequencer in its emit state until m_ready.
// Reset is synchronous and active low; the line buffer needs no clearing pass.
module bilinear_upscale_integer_top #(
    parameter int WIDTH_MAX  = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bui_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bui_pkg::CFGD_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bui_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           s_frame_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bui_pkg::PIX_W-1:0]      m_out_pixel,
    output logic [bui_pkg::OROW_W-1:0]     m_out_row,
    output logic [bui_pkg::OCOL_W-1:0]     m_out_col,
    output logic                           m_block_last
);

    bui_pkg::bui_cmd_t    cmd;
    bui_pkg::bui_status_t status;

    // Sequencer.
    bui_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    bui_datapath #(
        .WIDTH_MAX  (WIDTH_MAX),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_pixel   (m_out_pixel),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_block_last  (m_block_last)
    );

endmodule

FILE: rtl/bui_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bui_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/bui_ctrl.sv
// Controller state machine of the bilinear upscaler.
module bui_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bui_pkg::bui_status_t status,
    output bui_pkg::bui_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.capture = 1'b1;
                if (status.produce) begin
                    state_next = ST_CALC;
                end else begin
                    cmd.shift  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.blk_last) begin
                        cmd.shift  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_CALC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/bui_datapath.sv
// Datapath of the bilinear upscaler: position, line buffer, weights and output register.
module bui_datapath #(
    parameter int WIDTH_MAX  = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bui_pkg::bui_cmd_t              cmd,
    output bui_pkg::bui_status_t           status,
    input  logic                           cfg_wr_en,
    input  logic [bui_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bui_pkg::CFGD_W-1:0]     cfg_wr_data,
    input  logic [bui_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           s_frame_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bui_pkg::PIX_W-1:0]      m_out_pixel,
    output logic [bui_pkg::OROW_W-1:0]     m_out_row,
    output logic [bui_pkg::OCOL_W-1:0]     m_out_col,
    output logic                           m_block_last
);

    localparam int CW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
    localparam int WW = CW + 1;
    localparam int WC = (WW > bui_pkg::CFGW_W) ? WW : bui_pkg::CFGW_W;
    localparam int RW = bui_pkg::ROW_W;

    // Configuration registers.
    logic [bui_pkg::CFGW_W-1:0] cfg_w_reg;
    logic [bui_pkg::CFGH_W-1:0] cfg_h_reg;
    logic [bui_pkg::CFGF_W-1:0] cfg_f_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= 11'd640;
            cfg_h_reg <= 13'd480;
            cfg_f_reg <= 4'd2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bui_pkg::REG_WIDTH:  cfg_w_reg <= cfg_wr_data[bui_pkg::CFGW_W-1:0];
                bui_pkg::REG_HEIGHT: cfg_h_reg <= cfg_wr_data;
                bui_pkg::REG_FACTOR: cfg_f_reg <= cfg_wr_data[bui_pkg::CFGF_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes after clamping.
    logic [WC-1:0]               w_wide;
    logic [WW-1:0]               w_eff;
    logic [bui_pkg::CFGH_W-1:0]  h_eff;
    logic [bui_pkg::CFGF_W-1:0]  f_eff;

    always_comb begin
        w_wide = WC'(cfg_w_reg);
        if (w_wide < WC'(2)) begin
            w_wide = WC'(2);
        end
        if (w_wide > WC'(WIDTH_MAX)) begin
            w_wide = WC'(WIDTH_MAX);
        end
        w_eff = WW'(w_wide);
        h_eff = cfg_h_reg;
        if (h_eff < 13'd2) begin
            h_eff = 13'd2;
        end
        if (h_eff > 13'(bui_pkg::HEIGHT_MAX)) begin
            h_eff = 13'(bui_pkg::HEIGHT_MAX);
        end
        f_eff = cfg_f_reg;
        if (f_eff == 4'd0) begin
            f_eff = 4'd1;
        end
        if (f_eff > 4'(MAX_FACTOR)) begin
            f_eff = 4'(MAX_FACTOR);
        end
    end

    // Source position of the arriving item and the position after it.
    logic [CW-1:0]  col_reg, col_next, c_new;
    logic [RW-1:0]  row_reg, row_next, r_new;
    logic [CW-1:0]  c_cur_reg;
    logic [RW-1:0]  r_cur_reg;
    logic [CW-1:0]  col0;
    logic [RW-1:0]  row0;
    logic [RW:0]    row1;
    logic [RW:0]    rn;
    logic [WW-1:0]  cn;

    always_comb begin
        col0 = s_frame_start ? '0 : col_reg;
        row0 = s_frame_start ? '0 : row_reg;
        if ({1'b0, col0} >= w_eff) begin
            c_new = '0;
            row1  = {1'b0, row0} + 13'd1;
        end else begin
            c_new = col0;
            row1  = {1'b0, row0};
        end
        r_new = (row1 >= h_eff) ? '0 : row1[RW-1:0];
        cn = {1'b0, c_new} + WW'(1);
        rn = {1'b0, r_new} + 13'd1;
        if (cn >= w_eff) begin
            col_next = '0;
            row_next = (rn >= h_eff) ? '0 : rn[RW-1:0];
        end else begin
            col_next = cn[CW-1:0];
            row_next = r_new;
        end
    end

    // Line buffer holding the previous source row.
    logic [bui_pkg::PIX_W-1:0] px_reg;
    logic [bui_pkg::PIX_W-1:0] up_reg;
    logic [bui_pkg::PIX_W-1:0] ul_reg;
    logic [bui_pkg::PIX_W-1:0] lp_reg;
    logic [bui_pkg::PIX_W-1:0] rd_data;

    bui_ram #(
        .WIDTH (bui_pkg::PIX_W),
        .DEPTH (WIDTH_MAX)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (cmd.capture),
        .wr_addr (c_cur_reg),
        .wr_data (px_reg),
        .rd_en   (cmd.accept),
        .rd_addr (c_new),
        .rd_data (rd_data)
    );

    // Position, captured pixels and neighbor registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ul_reg  <= '0;
            lp_reg  <= '0;
        end else begin
            if (cmd.accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cmd.shift) begin
                ul_reg <= cmd.capture ? rd_data : up_reg;
                lp_reg <= px_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg    <= s_pixel;
            c_cur_reg <= c_new;
            r_cur_reg <= r_new;
        end
        if (cmd.capture) begin
            up_reg <= rd_data;
        end
    end

    // Offsets within the output block.
    logic [2:0] a_reg;
    logic [2:0] b_reg;
    logic [2:0] f_m1;
    logic       b_wrap;

    assign f_m1   = 3'(f_eff - 4'd1);
    assign b_wrap = (b_reg == f_m1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
        end else if (cmd.capture) begin
            a_reg <= '0;
            b_reg <= '0;
        end else if (cmd.load) begin
            if (b_wrap) begin
                b_reg <= '0;
                a_reg <= a_reg + 3'd1;
            end else begin
                b_reg <= b_reg + 3'd1;
            end
        end
    end

    // Weighted sum of the four neighbors.
    logic [3:0]                 fa, fb;
    logic [bui_pkg::SUM_W-1:0]  sum_reg;
    logic [15:0]                sum_full;

    always_comb begin
        fa = f_eff - {1'b0, a_reg};
        fb = f_eff - {1'b0, b_reg};
        sum_full = 16'(fa) * 16'(fb) * 16'(ul_reg)
                 + 16'(fa) * 16'(b_reg) * 16'(up_reg)
                 + 16'(a_reg) * 16'(fb) * 16'(lp_reg)
                 + 16'(a_reg) * 16'(b_reg) * 16'(px_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            sum_reg <= bui_pkg::SUM_W'(sum_full);
        end
    end

    // Division by f*f through the reciprocal table, and output coordinates.
    logic [bui_pkg::SUM_W+bui_pkg::RCP_W-1:0] quot_full;
    logic [15:0] orow_full;
    logic [16:0] ocol_full;

    always_comb begin
        quot_full = (bui_pkg::SUM_W+bui_pkg::RCP_W)'(sum_reg)
                  * (bui_pkg::SUM_W+bui_pkg::RCP_W)'(bui_pkg::RECIP[f_m1]);
        orow_full = 16'(RW'(r_cur_reg - 12'd1)) * 16'(f_eff) + 16'(a_reg);
        ocol_full = 17'(CW'(c_cur_reg - CW'(1))) * 17'(f_eff) + 17'(b_reg);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_out_pixel  <= quot_full[bui_pkg::RCP_SH +: bui_pkg::PIX_W];
            m_out_row    <= orow_full[bui_pkg::OROW_W-1:0];
            m_out_col    <= ocol_full[bui_pkg::OCOL_W-1:0];
            m_block_last <= (a_reg == f_m1) && b_wrap;
        end
    end

    // Status toward the controller.
    assign status.produce  = (r_cur_reg != '0) && (c_cur_reg != '0);
    assign status.out_free = !m_valid || m_ready;
    assign status.blk_last = (a_reg == f_m1) && b_wrap;

endmodule

FILE: rtl/bui_checker.sv
// Port-level assertion checker of the bilinear upscaler, with its bind.
`include "bilinear_upscale_integer_top_defines.svh"

module bui_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [bui_pkg::PIX_W-1:0]      m_out_pixel,
    input logic                           m_block_last
);

    // A waiting result stays offered.
    `BUI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)

    // A waiting result keeps its value and its block marker.
    `BUI_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_out_pixel) && $stable(m_block_last))

    // The block is busy reading the line buffer right after it takes an item.
    `BUI_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // Reset leaves no result offered.
    `BUI_ASSERT_NOW(a_reset_empty, $past(!aresetn), !m_valid)

endmodule

bind bilinear_upscale_integer_top bui_checker u_bui_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench of the integer bilinear upscaler.
module tb_top;

    // One output pixel with its coordinates.
    typedef struct packed {
        logic [bui_pkg::PIX_W-1:0]  pixel;
        logic [bui_pkg::OROW_W-1:0] row;
        logic [bui_pkg::OCOL_W-1:0] col;
        logic                       last;
    } out_pix_t;

    // Holds the expected output pixels and counts mismatches.
    class upscale_scoreboard;
        out_pix_t pending[$];
        int errors;

        function void note_pixel(out_pix_t exp_pix);
            pending.push_back(exp_pix);
        endfunction

        function void check_pixel(out_pix_t got);
            out_pix_t exp_pix;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output pixel %p", got);
                return;
            end
            exp_pix = pending.pop_front();
            if (exp_pix != got) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", exp_pix, got);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [bui_pkg::IDX_W-1:0] cfg_index = bui_pkg::REG_WIDTH;
    logic [bui_pkg::CFGD_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [bui_pkg::PIX_W-1:0] s_pixel = '0;
    logic s_frame_start = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [bui_pkg::PIX_W-1:0] m_out_pixel;
    logic [bui_pkg::OROW_W-1:0] m_out_row;
    logic [bui_pkg::OCOL_W-1:0] m_out_col;
    logic m_block_last;

    bilinear_upscale_integer_top u_top (.*);

    always #1 aclk = ~aclk;

    upscale_scoreboard sb = new();

    // Predictor state: configuration, line buffer and position.
    int unsigned cur_width = 640, cur_height = 480, cur_factor = 2;
    logic [7:0] line_buf [1024];
    logic [7:0] upper_left = 0, left_pix = 0;
    int unsigned row_cnt = 0, col_cnt = 0;
    int send_idle = 0, recv_idle = 0;
    longint cycles = 0;

    // Computes the output block caused by one accepted source pixel.
    function automatic void predict_block(logic [7:0] px, logic fs);
        int unsigned w, h, f, r, c, sum;
        logic [7:0] up;
        out_pix_t o;
        w = cur_width < 2 ? 2 : (cur_width > 1024 ? 1024 : cur_width);
        h = cur_height < 2 ? 2 : (cur_height > 4096 ? 4096 : cur_height);
        f = cur_factor < 1 ? 1 : (cur_factor > 8 ? 8 : cur_factor);
        if (fs) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        r = row_cnt;
        c = col_cnt;
        up = line_buf[c];
        if (r >= 1 && c >= 1) begin
            for (int a = 0; a < f; a++) begin
                for (int b = 0; b < f; b++) begin
                    sum = (f-a)*(f-b)*upper_left + (f-a)*b*up + a*(f-b)*left_pix + a*b*px;
                    o.pixel = bui_pkg::PIX_W'(sum / (f*f));
                    o.row = bui_pkg::OROW_W'((r-1)*f + a);
                    o.col = bui_pkg::OCOL_W'((c-1)*f + b);
                    o.last = (a == f-1 && b == f-1);
                    sb.note_pixel(o);
                end
            end
        end
        upper_left = up;
        left_pix = px;
        line_buf[c] = px;
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
    endfunction

    // Cycle counter with a timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls and result checking.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pixel({m_out_pixel, m_out_row, m_out_col, m_block_last});
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Sends one source pixel; valid drops only during idle cycles before it.
    task automatic send_pixel(logic [7:0] px, logic fs);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        predict_block(px, fs);
    endtask

    // Waits until all expected pixels arrived, then for the block to settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Drives one register write; the caller ends the write burst.
    task automatic write_reg(logic [bui_pkg::IDX_W-1:0] idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= bui_pkg::CFGD_W'(val);
        @(posedge aclk);
        case (idx)
            bui_pkg::REG_WIDTH:  cur_width = val & 16'h7FF;
            bui_pkg::REG_HEIGHT: cur_height = val & 16'h1FFF;
            default:             cur_factor = val & 4'hF;
        endcase
    endtask

    // Sets a frame shape after draining the pending output; the frame position is kept.
    task automatic set_shape(int unsigned w, int unsigned h, int unsigned f);
        drain();
        write_reg(bui_pkg::REG_WIDTH, w);
        write_reg(bui_pkg::REG_HEIGHT, h);
        write_reg(bui_pkg::REG_FACTOR, f);
        cfg_wr_en <= 1'b0;
    endtask

    // Sends n_pix source pixels of random content; a few pixels are extreme.
    task automatic send_frames(int unsigned n_pix, bit mark);
        int unsigned w;
        w = cur_width < 2 ? 2 : cur_width;
        for (int i = 0; i < n_pix; i++) begin
            logic [7:0] px;
            px = $urandom_range(9) == 0 ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
            send_pixel(px, mark && i == 0 ? 1'b1 : ($urandom_range(60) == 0 && i % w == 0));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, factor 8 and 1, out-of-range registers.
        set_shape(2, 2, 8);
        send_pixel(8'hFF, 1'b1); send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0); send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0); send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0); send_pixel(8'hFF, 1'b0);
        set_shape(0, 0, 0);
        send_pixel(8'h12, 1'b1); send_pixel(8'h34, 1'b0);
        send_pixel(8'h56, 1'b0); send_pixel(8'h78, 1'b0);
        set_shape(3, 1, 15);
        send_frames(6, 1);
        set_shape(2047, 8191, 1);
        send_frames(4, 1);

        // Random frames with several settings and idling profiles.
        send_idle = 19; recv_idle = 74;
        set_shape(5, 4, 2);
        send_frames(60, 1);
        set_shape(4, 3, 3);
        send_frames(24, 1);
        drain();
        send_idle = 74; recv_idle = 19;
        set_shape(1024, 3, 1);
        send_frames(40, 1);
        // Shrink the width in mid frame; the position wraps.
        set_shape(6, 5, 2);
        send_frames(30, 0);
        send_idle = 0; recv_idle = 0;
        set_shape(3, 3, 4);
        send_frames(30, 1);
        set_shape(7, 6, 1);
        send_frames(60, 1);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
